// ===== rtl/assert_macros.svh =====
// Assertion macros; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/ffra_pkg.sv =====
`timescale 1ns / 1ps
package ffra_pkg;
    localparam int MaxRegions = 64;
    localparam int IdxW       = $clog2(MaxRegions);
    localparam int CntW       = $clog2(MaxRegions + 1);
    localparam int AddrW      = 32;
    localparam int Handles    = 64;
    localparam int HandleW    = 6;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_LIVE  = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_NOGAP = 3'd3;
    localparam logic [2:0] ST_DEAD  = 3'd4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [HandleW-1:0]  handle;
        logic [31:0]         request_size;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] region_base;
        logic [31:0] free_bytes;
    } t_rsp;

    typedef struct packed {
        logic [AddrW-1:0]   start;
        logic [AddrW-1:0]   length;
        logic [HandleW-1:0] owner;
    } t_entry;
endpackage

// ===== rtl/ffra_table.sv =====
`timescale 1ns / 1ps
module ffra_table import ffra_pkg::*; (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IdxW-1:0] i_waddr,
    input  t_entry          i_wdata,
    input  logic [IdxW-1:0] i_raddr,
    output t_entry          o_rdata
);
    t_entry r_mem [MaxRegions];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/first_fit_region_allocator.sv =====
`timescale 1ns / 1ps
// First-fit region allocator.
// Request channel: i_req_valid / o_req_stall with payload i_req (t_req).
// Result channel: o_rsp_valid / i_rsp_stall with payload o_rsp (t_rsp).
// Config channel: i_cfg_valid / o_cfg_ready writes cache_size; ready is
// always high, write only while idle.
// One request is worked at a time. The region table lives in one
// single-port-read memory; a scan reads one entry per cycle.
// Allocate: check, scan the entries for the first fitting gap, then
// shift entries up for the insert. Free: scan to the owner, then shift
// the entries behind it down. Refusals on handle or size skip the scan.
// The result is held in an output register; the next request is taken
// once the result register is empty or being drained. A stalled result
// holds. Reset clears the count, live bits, used bytes and cache size;
// table contents need no clearing.
module first_fit_region_allocator import ffra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
`include "assert_macros.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHUP  = 3'd3;
    localparam logic [2:0] S_SHDN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state;
    logic [AddrW-1:0]   r_cache_size;
    logic [AddrW-1:0]   r_used;
    logic [CntW-1:0]    r_count;
    logic [Handles-1:0] r_live;
    t_req               r_req;
    logic [CntW-1:0]    r_idx;
    logic [CntW-1:0]    r_slot;
    logic [AddrW-1:0]   r_next;
    logic [2:0]         r_status;
    logic [AddrW-1:0]   r_base;
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    logic               we;
    logic [IdxW-1:0]    waddr, raddr;
    t_entry             wdata, rdata;

    logic [AddrW-1:0]   free_now;
    logic [AddrW-1:0]   lead, gap;
    logic [AddrW-1:0]   ent_end;
    logic               take, out_free, at_end;

    assign free_now = (r_used > r_cache_size) ? '0 : r_cache_size - r_used;
    assign out_free = !r_rsp_valid || !i_rsp_stall;
    assign take     = i_req_valid && !o_req_stall;
    assign o_req_stall = (r_state != S_IDLE) || !out_free;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    ffra_table u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // rdata holds entry r_idx during S_SCAN (the table read is registered)
    assign at_end  = (r_idx == r_count);
    assign lead    = at_end ? r_cache_size : rdata.start;
    assign gap     = (lead >= r_next) ? lead - r_next : '0;
    assign ent_end = rdata.start + rdata.length;

    always_comb begin
        we      = 1'b0;
        waddr   = r_idx[IdxW-1:0];
        wdata   = rdata;
        raddr   = r_idx[IdxW-1:0];
        unique case (r_state)
            S_IDLE: begin
                raddr = '0;
            end
            S_SCAN: begin
                // on an insert hit, fetch the last entry for the shift up
                if ((r_req.req_type == REQ_ALLOC) && !at_end
                    && (gap >= r_req.request_size)) begin
                    raddr = r_count[IdxW-1:0] - 1'b1;
                end else begin
                    raddr = r_idx[IdxW-1:0] + 1'b1;
                end
            end
            S_SHUP: begin
                // r_idx counts down; rdata = entry r_idx - 1
                raddr = r_idx[IdxW-1:0] - 2'd2;
                we    = 1'b1;
                waddr = r_idx[IdxW-1:0];
            end
            S_SHDN: begin
                // rdata = entry r_idx + 1
                raddr = r_idx[IdxW-1:0] + 2'd2;
                we    = 1'b1;
                waddr = r_idx[IdxW-1:0];
            end
            default: begin
                raddr = r_idx[IdxW-1:0];
            end
        endcase
        if (r_state == S_DONE) begin
            we    = (r_req.req_type == REQ_ALLOC) && (r_status == ST_OK);
            waddr = r_idx[IdxW-1:0];
            wdata = '{start: r_next, length: r_req.request_size, owner: r_req.handle};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cache_size <= '0;
            r_used       <= '0;
            r_count      <= '0;
            r_live       <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cache_size <= i_cfg_data;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_req   <= i_req;
                        r_state <= S_CHECK;
                        r_idx   <= '0;
                        r_next  <= '0;
                        r_base  <= '0;
                    end
                end
                S_CHECK: begin
                    if (r_req.req_type == REQ_ALLOC) begin
                        if (r_live[r_req.handle]) begin
                            r_status <= ST_LIVE;
                            r_state  <= S_DONE;
                        end else if (free_now < r_req.request_size) begin
                            r_status <= ST_SHORT;
                            r_state  <= S_DONE;
                        end else if (r_count == CntW'(MaxRegions)) begin
                            r_status <= ST_NOGAP;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else if (!r_live[r_req.handle]) begin
                        r_status <= ST_DEAD;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_req.req_type == REQ_ALLOC) begin
                        if (gap >= r_req.request_size) begin
                            r_status <= ST_OK;
                            r_base   <= r_next;
                            if (at_end) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SHUP;
                                r_idx   <= r_count;
                            end
                            r_used  <= r_used + r_req.request_size;
                            r_count <= r_count + 1'b1;
                            r_live[r_req.handle] <= 1'b1;
                        end else if (at_end) begin
                            r_status <= ST_NOGAP;
                            r_state  <= S_DONE;
                        end else begin
                            r_next <= ent_end;
                            r_idx  <= r_idx + 1'b1;
                        end
                    end else begin
                        if (at_end) begin
                            r_status <= ST_DEAD;
                            r_state  <= S_DONE;
                        end else if (rdata.owner == r_req.handle) begin
                            r_status <= ST_OK;
                            r_used   <= (r_used > rdata.length) ? r_used - rdata.length
                                                                 : '0;
                            r_count  <= r_count - 1'b1;
                            r_live[r_req.handle] <= 1'b0;
                            if (CntW'(r_idx + 1'b1) < r_count) begin
                                r_state <= S_SHDN;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_SHUP: begin
                    // slot index held in r_slot
                    if (r_idx == '0 || (r_idx - 1'b1) == r_slot) begin
                        r_idx   <= r_slot;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_SHDN: begin
                    if (CntW'(r_idx + 2'd2) > r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_rsp.status       <= r_status;
                        r_rsp.region_base  <= (r_status == ST_OK) ? r_base : '0;
                        r_rsp.free_bytes   <= free_now;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_slot <= r_idx;
        end
    end

    `ASSERT_CLK(a_count_max, i_clk, i_rst_n, r_count <= CntW'(MaxRegions),
        "region count above table depth")
    `ASSERT_CLK(a_stall_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_req_stall,
        "request accepted while busy")
    `ASSERT_CLK(a_rsp_from_done, i_clk, i_rst_n,
        ($rose(r_rsp_valid)) |-> ($past(r_state) == S_DONE),
        "result raised outside done state")
endmodule

// ===== test/ffra_checker.sv =====
`timescale 1ns / 1ps
module ffra_checker import ffra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  t_req        i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  t_rsp        i_rsp,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    logic [31:0]        range_size;
    logic [31:0]        tbl_start [MaxRegions];
    logic [31:0]        tbl_len   [MaxRegions];
    logic [HandleW-1:0] tbl_owner [MaxRegions];
    int                 tbl_count;
    logic [Handles-1:0] live_mask;
    logic [31:0]        used_total;
    t_rsp               rsp_queue [$];
    int                 fail_count;

    assign o_fail_count = fail_count;

    initial o_pending = 0;

    function automatic logic [31:0] bytes_left();
        return (used_total > range_size) ? 32'd0 : range_size - used_total;
    endfunction

    task automatic apply_alloc(input logic [HandleW-1:0] h, input logic [31:0] size,
                               output logic [2:0] st, output logic [31:0] base);
        logic [32:0] nxt;
        logic [32:0] lead;
        logic [32:0] gap;
        int          slot;
        nxt  = '0;
        slot = -1;
        base = '0;
        if (live_mask[h]) begin
            st = ST_LIVE;
        end else if (bytes_left() < size) begin
            st = ST_SHORT;
        end else if (tbl_count >= MaxRegions) begin
            st = ST_NOGAP;
        end else begin
            for (int i = 0; i <= tbl_count && slot < 0; i++) begin
                lead = (i < tbl_count) ? {1'b0, tbl_start[i]} : {1'b0, range_size};
                gap  = (lead >= nxt) ? lead - nxt : 33'd0;
                if (gap >= {1'b0, size}) begin
                    slot = i;
                end else if (i < tbl_count) begin
                    nxt = {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]};
                end
            end
            if (slot < 0) begin
                st = ST_NOGAP;
            end else begin
                for (int i = tbl_count; i > slot; i--) begin
                    tbl_start[i] = tbl_start[i-1];
                    tbl_len[i]   = tbl_len[i-1];
                    tbl_owner[i] = tbl_owner[i-1];
                end
                tbl_start[slot] = nxt[31:0];
                tbl_len[slot]   = size;
                tbl_owner[slot] = h;
                tbl_count++;
                live_mask[h] = 1'b1;
                used_total   = used_total + size;
                base = nxt[31:0];
                st   = ST_OK;
            end
        end
    endtask

    task automatic apply_free(input logic [HandleW-1:0] h, output logic [2:0] st);
        int hit;
        hit = -1;
        st  = ST_DEAD;
        if (live_mask[h]) begin
            for (int i = 0; i < tbl_count && hit < 0; i++)
                if (tbl_owner[i] == h) hit = i;
            if (hit >= 0) begin
                used_total = (used_total > tbl_len[hit]) ? used_total - tbl_len[hit] : 32'd0;
                for (int k = hit; k + 1 < tbl_count; k++) begin
                    tbl_start[k] = tbl_start[k+1];
                    tbl_len[k]   = tbl_len[k+1];
                    tbl_owner[k] = tbl_owner[k+1];
                end
                tbl_count--;
                live_mask[h] = 1'b0;
                st = ST_OK;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp        want;
        logic [2:0]  st;
        logic [31:0] base;
        if (!i_rst_n) begin
            range_size = '0;
            tbl_count  = 0;
            live_mask  = '0;
            used_total = '0;
            fail_count = 0;
            rsp_queue.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (rsp_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %p", i_rsp);
                end else begin
                    want = rsp_queue.pop_front();
                    if (i_rsp !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected st=%0d base=%h free=%h, ",
                                      "got st=%0d base=%h free=%h"},
                                     want.status, want.region_base, want.free_bytes,
                                     i_rsp.status, i_rsp.region_base, i_rsp.free_bytes);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                range_size = i_cfg_data;
            if (i_req_valid && !i_req_stall) begin
                base = '0;
                if (i_req.req_type == REQ_ALLOC)
                    apply_alloc(i_req.handle, i_req.request_size, st, base);
                else
                    apply_free(i_req.handle, st);
                want.status      = st;
                want.region_base = (st == ST_OK) ? base : 32'd0;
                want.free_bytes  = bytes_left();
                rsp_queue.insert(rsp_queue.size(), want);
            end
        end
        o_pending = rsp_queue.size();
    end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import ffra_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_stall;
    t_req        i_req = '0;
    logic        o_rsp_valid;
    logic        i_rsp_stall = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic [31:0] cur_size = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    first_fit_region_allocator uut (
        .i_clk, .i_rst_n, .i_req_valid, .o_req_stall, .i_req,
        .o_rsp_valid, .i_rsp_stall, .o_rsp, .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    ffra_checker chk (
        .i_clk, .i_rst_n, .i_req_valid, .i_req_stall(o_req_stall), .i_req,
        .i_rsp_valid(o_rsp_valid), .i_rsp_stall, .i_rsp(o_rsp),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // result-side backpressure: runs of free flow, short stalls, rare long stalls
    always @(posedge i_clk) begin
        int run;
        int pick;
        if (run <= 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                run = $urandom_range(1, 40);
                i_rsp_stall <= 1'b0;
            end else if (pick < 93) begin
                run = $urandom_range(1, 3);
                i_rsp_stall <= 1'b1;
            end else begin
                run = $urandom_range(15, 60);
                i_rsp_stall <= 1'b1;
            end
        end
        run--;
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input logic kind, input int h, input logic [31:0] size);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid        <= 1'b1;
        i_req.req_type     <= kind;
        i_req.handle       <= h[HandleW-1:0];
        i_req.request_size <= size;
        @(posedge i_clk iff !o_req_stall);
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (140) @(posedge i_clk);
    endtask

    task automatic set_range(input logic [31:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        cur_size = v;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8) return 32'd0;
        if (p < 16) return $urandom();
        if (p < 22) return cur_size;
        return $urandom_range(0, (cur_size >> 5) + 1);
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            if ($urandom_range(0, 99) < 60)
                send(REQ_ALLOC, $urandom_range(0, 63), rand_size());
            else
                send(REQ_FREE, $urandom_range(0, 63), $urandom());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty range
        send(REQ_ALLOC, 0, 32'd0);
        send(REQ_ALLOC, 0, 32'hFFFF_FFFF);
        send(REQ_ALLOC, 1, 32'd1);
        send(REQ_FREE, 2, 32'd0);
        send(REQ_FREE, 0, 32'hFFFF_FFFF);
        // full address range
        set_range(32'hFFFF_FFFF);
        send(REQ_ALLOC, 63, 32'hFFFF_FFFF);
        send(REQ_ALLOC, 1, 32'd0);
        send(REQ_ALLOC, 2, 32'd1);
        send(REQ_FREE, 63, 32'd0);
        send(REQ_ALLOC, 2, 32'h8000_0000);
        send(REQ_ALLOC, 3, 32'h7FFF_FFFF);
        send(REQ_FREE, 1, 32'd0);
        send(REQ_FREE, 2, 32'd0);
        send(REQ_FREE, 3, 32'd0);
        // fragmentation and a shrunk range
        set_range(32'd1000);
        send(REQ_ALLOC, 10, 32'd300);
        send(REQ_ALLOC, 11, 32'd300);
        send(REQ_ALLOC, 12, 32'd300);
        send(REQ_FREE, 11, 32'd0);
        send(REQ_ALLOC, 13, 32'd350);
        send(REQ_ALLOC, 14, 32'd250);
        set_range(32'd500);
        send(REQ_ALLOC, 15, 32'd0);
        send(REQ_FREE, 12, 32'd0);
        send(REQ_ALLOC, 16, 32'd1);

        set_range(32'd4096);
        random_phase(300);
        set_range(32'd64);
        random_phase(200);
        set_range(32'hFFFF_FFFF);
        random_phase(250);
        set_range($urandom());
        random_phase(250);
        set_range(32'd100);
        random_phase(150);
        set_range(32'd0);
        random_phase(100);
        set_range(32'd200000);
        random_phase(300);

        i_req_valid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
